[hw/rtl/dcpw_pkg.sv]
// Shared types, constants and calendar helper functions for the date check unit.
`default_nettype none

package dcpw_pkg;

	// One input beat: a calendar date and time of day.
	typedef struct packed {
		logic [13:0] year_value;
		logic [3:0]  month_value;
		logic [4:0]  day_value;
		logic [4:0]  hour_value;
		logic [5:0]  minute_value;
		logic [5:0]  second_value;
	} date_item_t;

	// One result beat: validity, packed FAT timestamp and day of week.
	typedef struct packed {
		logic        date_valid;
		logic [31:0] dos_stamp;
		logic [2:0]  week_day;
	} date_result_t;

	// Year window that the 7-bit FAT year field can hold.
	localparam int unsigned YEAR_BASE = 1980;
	localparam int unsigned YEAR_SPAN = 127;

	// Limits of the time-of-day fields and of the month.
	localparam int unsigned HOUR_MAX   = 23;
	localparam int unsigned MINUTE_MAX = 59;
	localparam int unsigned SECOND_MAX = 59;
	localparam int unsigned MONTH_MAX  = 12;

	// Reciprocal for division by 100 of a 14-bit value: q = (x * 5243) >> 19.
	localparam int unsigned RECIP_100       = 5243;
	localparam int unsigned RECIP_100_SHIFT = 19;

	// Reciprocal for division by 7 of an 11-bit value: q = (x * 4682) >> 15.
	localparam int unsigned RECIP_7       = 4682;
	localparam int unsigned RECIP_7_SHIFT = 15;

	// Month term (mm * 26 - 2) / 10 of the weekday formula, where mm is the month
	// shifted so that March is 1 and January and February belong to the prior year.
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] t;
		case (m)
			4'd0:    t = 6'd25;
			4'd1:    t = 6'd28;
			4'd2:    t = 6'd31;
			4'd3:    t = 6'd2;
			4'd4:    t = 6'd5;
			4'd5:    t = 6'd7;
			4'd6:    t = 6'd10;
			4'd7:    t = 6'd12;
			4'd8:    t = 6'd15;
			4'd9:    t = 6'd18;
			4'd10:   t = 6'd20;
			4'd11:   t = 6'd23;
			4'd12:   t = 6'd25;
			4'd13:   t = 6'd28;
			4'd14:   t = 6'd31;
			default: t = 6'd33;
		endcase
		return t;
	endfunction

	// Number of days in a month; months outside 1 to 12 fall to 31.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/dcpw_div100.sv]
// Quotient of a 14-bit year by 100 through a reciprocal multiplication.
`default_nettype none

module dcpw_div100 (
	input  wire logic [13:0] dividend,
	output logic      [7:0]  quotient
);

	logic [26:0] product;

	// The scaled reciprocal is exact for every 14-bit dividend.
	assign product  = 27'(dividend) * 27'(dcpw_pkg::RECIP_100);
	assign quotient = product[dcpw_pkg::RECIP_100_SHIFT +: 8];

endmodule

`default_nettype wire

[hw/rtl/date_check_pack_weekday_unit.sv]
// Top level of the date check, FAT timestamp packing and weekday unit.
`default_nettype none

// The unit takes one date and time beat in every clock cycle and never stalls:
// busy stays low, so every cycle with start high is an accepted beat. Each
// beat gives exactly one result beat, shown for one cycle with done high.
// The beat passes the input register, a stage that forms the quotients by 100,
// a stage that forms the remainders, the date check and the weekday sum, and
// the result register that holds the remainder by 7 and the packed stamp.
// Results come out in input order and cannot be held off by the receiver, so
// it must take done beats as they come.
module date_check_pack_weekday_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire dcpw_pkg::date_item_t   date_item,
	output logic                        done,
	output dcpw_pkg::date_result_t      date_result
);

	// Stage valid bits and the result strobe.
	logic valid_s1, valid_s2, valid_s3, done_q;

	// Input register.
	dcpw_pkg::date_item_t item_s1;

	// Stage 2: quotients by 100 and the shifted weekday year.
	dcpw_pkg::date_item_t item_s2;
	logic [7:0]  year_cent_s2;
	logic [7:0]  wk_cent_s2;
	logic [13:0] wk_year_s2;
	logic        wk_neg_s2;
	logic        time_ok_s2;

	// Stage 3: validity, year window and the weekday sum.
	dcpw_pkg::date_item_t item_s3;
	logic        ok_s3;
	logic        in_window_s3;
	logic [6:0]  year_off_s3;
	logic [10:0] wk_sum_s3;

	dcpw_pkg::date_result_t result_q;

	// The unit accepts a beat in every cycle.
	assign busy = 1'b0;

	// Control: valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// Input register captures each accepted beat.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= date_item;
		end
	end

	// January and February count in the prior year for the weekday; year zero
	// then becomes year minus one, which the later stage handles on its own.
	logic        early_month_s1;
	logic [13:0] wk_year_s1;
	logic [7:0]  year_cent_s1;
	logic [7:0]  wk_cent_s1;

	assign early_month_s1 = (item_s1.month_value <= 4'd2);
	assign wk_year_s1     = item_s1.year_value - 14'(early_month_s1);

	dcpw_div100 u_div_year (
		.dividend (item_s1.year_value),
		.quotient (year_cent_s1)
	);

	dcpw_div100 u_div_wk (
		.dividend (wk_year_s1),
		.quotient (wk_cent_s1)
	);

	always_ff @(posedge clk) begin
		item_s2      <= item_s1;
		year_cent_s2 <= year_cent_s1;
		wk_cent_s2   <= wk_cent_s1;
		wk_year_s2   <= wk_year_s1;
		wk_neg_s2    <= early_month_s1 && (item_s1.year_value == 14'd0);
		time_ok_s2   <= (item_s1.hour_value <= 5'(dcpw_pkg::HOUR_MAX))
			&& (item_s1.minute_value <= 6'(dcpw_pkg::MINUTE_MAX))
			&& (item_s1.second_value <= 6'(dcpw_pkg::SECOND_MAX));
	end

	// Remainders by 100, the leap rule, the day check and the weekday sum.
	logic [13:0] year_rem_w;
	logic [13:0] wk_rem_w;
	logic [6:0]  wk_rem_s2;
	logic [7:0]  wk_cent_eff;
	logic [6:0]  wk_yterm;
	logic        leap_s2;
	logic        date_ok_s2;
	logic [10:0] wk_sum_w;
	logic [13:0] year_off_w;

	assign year_rem_w = item_s2.year_value - 14'(year_cent_s2) * 14'd100;
	assign wk_rem_w   = wk_year_s2 - 14'(wk_cent_s2) * 14'd100;
	assign wk_rem_s2  = wk_rem_w[6:0];

	// Divisible by 400 means divisible by 100 and by 16.
	assign leap_s2 = (item_s2.year_value[1:0] == 2'd0)
		&& ((year_rem_w[6:0] != 7'd0) || (item_s2.year_value[3:0] == 4'd0));

	assign date_ok_s2 = time_ok_s2
		&& (item_s2.month_value != 4'd0)
		&& (item_s2.month_value <= 4'(dcpw_pkg::MONTH_MAX))
		&& (item_s2.day_value != 5'd0)
		&& (item_s2.day_value <= dcpw_pkg::month_days(item_s2.month_value, leap_s2));

	// Year minus one has century zero, year-in-century minus one and a zero quarter.
	assign wk_cent_eff = wk_neg_s2 ? 8'd0 : wk_cent_s2;
	assign wk_yterm    = wk_neg_s2 ? 7'd0 : (wk_rem_s2 + 7'(wk_rem_s2[6:2]));
	assign wk_sum_w    = 11'(item_s2.day_value)
		+ 11'(dcpw_pkg::month_term(item_s2.month_value))
		+ 11'(wk_yterm)
		+ 11'(wk_cent_eff[7:2])
		+ 11'(wk_cent_eff) * 11'd5
		- 11'(wk_neg_s2);

	assign year_off_w = item_s2.year_value - 14'(dcpw_pkg::YEAR_BASE);

	always_ff @(posedge clk) begin
		item_s3      <= item_s2;
		ok_s3        <= date_ok_s2;
		in_window_s3 <= (item_s2.year_value >= 14'(dcpw_pkg::YEAR_BASE))
			&& (year_off_w <= 14'(dcpw_pkg::YEAR_SPAN));
		year_off_s3  <= year_off_w[6:0];
		wk_sum_s3    <= wk_sum_w;
	end

	// Weekday is the sum modulo 7; the stamp is packed only for valid dates in the window.
	logic [23:0] wk_prod;
	logic [8:0]  wk_quot;
	logic [10:0] wk_mod_w;
	logic [31:0] stamp_w;

	assign wk_prod  = 24'(wk_sum_s3) * 24'(dcpw_pkg::RECIP_7);
	assign wk_quot  = wk_prod[dcpw_pkg::RECIP_7_SHIFT +: 9];
	assign wk_mod_w = wk_sum_s3 - 11'(wk_quot) * 11'd7;

	assign stamp_w = (ok_s3 && in_window_s3)
		? {year_off_s3, item_s3.month_value, item_s3.day_value, item_s3.hour_value,
			item_s3.minute_value, item_s3.second_value[5:1]}
		: 32'd0;

	always_ff @(posedge clk) begin
		result_q.date_valid <= ok_s3;
		result_q.dos_stamp  <= stamp_w;
		result_q.week_day   <= wk_mod_w[2:0];
	end

	assign done        = done_q;
	assign date_result = result_q;

	// Every accepted beat yields a result beat after the fixed latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted beat produced no result beat");

	// A result that reports an invalid date carries a zero stamp.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !date_result.date_valid) |-> (date_result.dos_stamp == 32'd0))
		else $error("invalid date with nonzero stamp");

	// The weekday remainder never reaches seven.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (date_result.week_day != 3'd7))
		else $error("weekday out of range");

	// A nonzero stamp only comes from a valid date.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (date_result.dos_stamp != 32'd0)) |-> date_result.date_valid)
		else $error("stamp packed for an invalid date");

endmodule

`default_nettype wire
